>>> rtl/core/hbf_pkg.sv
package hbf_pkg;

    localparam int WINDOW_LEN  = 47;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 18;
    localparam int COEF_COUNT  = 13;
    localparam int PAIR_COUNT  = COEF_COUNT - 1;
    localparam int CENTER_TAP  = (WINDOW_LEN - 1) / 2;
    localparam int FILL_BITS   = 6;

    localparam int PRE_BITS    = SAMPLE_BITS + 1;
    localparam int PROD_BITS   = PRE_BITS + COEF_BITS;
    localparam int GROUP_SIZE  = 4;
    localparam int GROUP_COUNT = (COEF_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GROUP_BITS  = PROD_BITS + 2;
    localparam int SUM_BITS    = PROD_BITS + 4;

    // Q1.17, outer pair first; last entry is the center tap (0.5)
    localparam logic signed [COEF_BITS-1:0] C_COEF [COEF_COUNT] = '{
        -18'sd131,   18'sd222,   -18'sd400,  18'sd663,  -18'sd1036,
        18'sd1556,   -18'sd2151, 18'sd3317,  -18'sd4879, 18'sd7541,
        -18'sd13412, 18'sd41554, 18'sd65536
    };

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          block_end_in;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] filtered_out;
        logic                          block_end_out;
    } t_out_beat;

endpackage

>>> rtl/core/hbf_delay_cell.sv
module hbf_delay_cell
    import hbf_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_shift,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);

    logic signed [SAMPLE_BITS-1:0] r_sample;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sample <= i_sample;
        end
    end

    assign o_sample = r_sample;

endmodule

>>> rtl/core/hbf_mac_cell.sv
module hbf_mac_cell
    import hbf_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [SAMPLE_BITS-1:0] i_tap_a,
    input  logic signed [SAMPLE_BITS-1:0] i_tap_b,
    input  logic signed [COEF_BITS-1:0]   i_coef,
    output logic signed [PROD_BITS-1:0]   o_product
);

    logic signed [PRE_BITS-1:0]  r_pre;
    logic signed [PROD_BITS-1:0] r_prod;

    // symmetric pair is pre-added so one multiplier serves two taps
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pre  <= PRE_BITS'(i_tap_a) + PRE_BITS'(i_tap_b);
            r_prod <= r_pre * i_coef;
        end
    end

    assign o_product = r_prod;

endmodule

>>> rtl/core/hbf_sum.sv
module hbf_sum
    import hbf_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [PROD_BITS-1:0]   i_products [COEF_COUNT],
    output logic signed [SAMPLE_BITS-1:0] o_result
);

    localparam logic signed [SUM_BITS-1:0] ROUND_BIAS = SUM_BITS'(1) <<< (COEF_BITS - 2);
    localparam logic signed [SUM_BITS-1:0] SAT_HI =
        SUM_BITS'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_BITS-1:0] SAT_LO = -SAT_HI - SUM_BITS'(1);

    logic signed [GROUP_BITS-1:0] r_part [GROUP_COUNT];
    logic signed [GROUP_BITS-1:0] n_part [GROUP_COUNT];
    logic signed [SUM_BITS-1:0]   r_total;
    logic signed [SUM_BITS-1:0]   n_total;
    logic signed [SUM_BITS-1:0]   w_biased;
    logic signed [SUM_BITS-1:0]   w_shifted;

    always_comb begin
        for (int g = 0; g < GROUP_COUNT; g++) begin
            n_part[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                if (g * GROUP_SIZE + j < COEF_COUNT) begin
                    n_part[g] = n_part[g] + GROUP_BITS'(i_products[g * GROUP_SIZE + j]);
                end
            end
        end
        n_total = '0;
        for (int g = 0; g < GROUP_COUNT; g++) begin
            n_total = n_total + SUM_BITS'(r_part[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_part  <= n_part;
            r_total <= n_total;
        end
    end

    // round half up, then clamp to the sample range
    assign w_biased  = r_total + ROUND_BIAS;
    assign w_shifted = w_biased >>> (COEF_BITS - 1);

    always_comb begin
        priority if (w_shifted > SAT_HI) begin
            o_result = SAT_HI[SAMPLE_BITS-1:0];
        end else if (w_shifted < SAT_LO) begin
            o_result = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            o_result = w_shifted[SAMPLE_BITS-1:0];
        end
    end

endmodule

>>> rtl/core/halfband_fir_filter.sv
// 47-tap half-band FIR, one sample beat in and one result beat out per cycle.
// An accepted sample beat's result passes the delay line cell, pre-add, multiply,
// two adder-tree levels and the round/saturate output register, in that order.
// Throughput: 1 beat per cycle; the pipeline stalls as a whole on output backpressure.
// Reset (i_rst_n, synchronous, active low) clears the fill count and valid flags;
// the first 46 samples after reset give no result.
module halfband_fir_filter
    import hbf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    localparam int PIPE_DEPTH = 5;

    logic                          w_en;
    logic                          w_accept;
    logic                          w_full_next;
    logic [FILL_BITS-1:0]          r_fill;
    logic [PIPE_DEPTH-1:0]         r_vld;
    logic [PIPE_DEPTH-1:0]         r_blk;
    logic                          r_out_valid;
    t_out_beat                     r_out;
    logic signed [SAMPLE_BITS-1:0] w_line [WINDOW_LEN];
    logic signed [PROD_BITS-1:0]   w_prod [COEF_COUNT];
    logic signed [SAMPLE_BITS-1:0] w_result;

    assign w_en        = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && w_en;
    assign w_full_next = (r_fill >= FILL_BITS'(WINDOW_LEN - 1));

    // delay line: newest sample enters the top cell, oldest sits in cell 0
    for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_line
        if (i == WINDOW_LEN - 1) begin : g_head
            hbf_delay_cell u_cell (
                .i_clk    (i_clk),
                .i_shift  (w_accept),
                .i_sample (i_in_beat.sample_in),
                .o_sample (w_line[i])
            );
        end else begin : g_body
            hbf_delay_cell u_cell (
                .i_clk    (i_clk),
                .i_shift  (w_accept),
                .i_sample (w_line[i+1]),
                .o_sample (w_line[i])
            );
        end
    end

    for (genvar k = 0; k < COEF_COUNT; k++) begin : g_mac
        if (k == PAIR_COUNT) begin : g_center
            hbf_mac_cell u_mac (
                .i_clk     (i_clk),
                .i_en      (w_en),
                .i_tap_a   (w_line[CENTER_TAP]),
                .i_tap_b   ('0),
                .i_coef    (C_COEF[k]),
                .o_product (w_prod[k])
            );
        end else begin : g_pair
            hbf_mac_cell u_mac (
                .i_clk     (i_clk),
                .i_en      (w_en),
                .i_tap_a   (w_line[2*k]),
                .i_tap_b   (w_line[WINDOW_LEN-1-2*k]),
                .i_coef    (C_COEF[k]),
                .o_product (w_prod[k])
            );
        end
    end

    hbf_sum u_sum (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_products (w_prod),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            if (w_accept && (r_fill < FILL_BITS'(WINDOW_LEN))) begin
                r_fill <= r_fill + FILL_BITS'(1);
            end
            // stage 0 flags a fresh full window sitting in the delay line
            r_vld       <= {r_vld[PIPE_DEPTH-2:0], w_accept && w_full_next};
            r_out_valid <= r_vld[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_blk               <= {r_blk[PIPE_DEPTH-2:0], i_in_beat.block_end_in};
            r_out.filtered_out  <= w_result;
            r_out.block_end_out <= r_blk[PIPE_DEPTH-1];
        end
    end

    assign o_in_ready  = w_en;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule
